### rtl/ttpp_pkg.sv
`default_nettype none
package ttpp_pkg;

    localparam int PAGE_W     = 7;
    localparam int NUM_PAGES  = 128;
    localparam int RING_AW    = 10;
    localparam int WINDOW_MAX = 1024;
    localparam int CNT_W      = 11;
    localparam int HEAT_W     = 16;
    localparam int IDLE_W     = 8;
    localparam int AGE_W      = 10;
    localparam int TIER_W     = 2;
    localparam int CAP_W      = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int HEAT_TAB_N = 128;

    localparam logic [HEAT_W-1:0] HEAT_ONE   = 16'd32768;
    localparam logic [HEAT_W-1:0] HEAT_RESET = 16'd16384;
    localparam logic [63:0]       EXP_STEP   = 64'd1943123559;

    localparam int RESET_TOP = 10;
    localparam int RESET_MID = 30;

    localparam logic [TIER_W-1:0] TIER_TOP  = 2'd0;
    localparam logic [TIER_W-1:0] TIER_MID  = 2'd1;
    localparam logic [TIER_W-1:0] TIER_SLOW = 2'd2;
    localparam logic [TIER_W-1:0] TIER_NONE = 2'd3;

    localparam logic [2:0] REG_TOP_CAP   = 3'd0;
    localparam logic [2:0] REG_MID_CAP   = 3'd1;
    localparam logic [2:0] REG_TOP_LIMIT = 3'd2;
    localparam logic [2:0] REG_MID_LIMIT = 3'd3;
    localparam logic [2:0] REG_STALE     = 3'd4;
    localparam logic [2:0] REG_COOL_PER  = 3'd5;
    localparam logic [2:0] REG_COOL_STEP = 3'd6;
    localparam logic [2:0] REG_WIN_LEN   = 3'd7;

    typedef struct packed {
        logic [TIER_W-1:0] tier;
        logic [HEAT_W-1:0] heat;
        logic [IDLE_W-1:0] idle;
        logic [AGE_W-1:0]  age;
    } t_cell;

    typedef logic [HEAT_W-1:0] t_heat_tab [HEAT_TAB_N];

    // 1 - 0.5*exp(-0.1*n) in Q1.15, exponent kept in Q0.31
    function automatic t_heat_tab f_build_heat();
        t_heat_tab   tab;
        logic [63:0] e;
        e = 64'd1 << 31;
        for (int k = 0; k < HEAT_TAB_N; k++) begin
            tab[k] = 16'(64'd32768 - ((e + (64'd1 << 16)) >> 17));
            e = (e * EXP_STEP + (64'd1 << 30)) >> 31;
        end
        return tab;
    endfunction

    localparam t_heat_tab HEAT_TAB = f_build_heat();

    function automatic logic [HEAT_W-1:0] f_heat(input logic [CNT_W-1:0] n);
        if (n >= CNT_W'(HEAT_TAB_N))
            return HEAT_ONE;
        return HEAT_TAB[n[6:0]];
    endfunction

endpackage
`default_nettype wire

### rtl/ttpp_if.sv
`default_nettype none
interface ttpp_req_if;
    logic                       valid;
    logic                       ready;
    logic [ttpp_pkg::PAGE_W-1:0] page;
    modport source (output valid, output page, input ready);
    modport sink (input valid, input page, output ready);
endinterface

interface ttpp_res_if;
    logic                         valid;
    logic                         ready;
    logic [ttpp_pkg::TIER_W-1:0]  hit_tier;
    logic [ttpp_pkg::CNT_W-1:0]   window_hits;
    logic [ttpp_pkg::HEAT_W-1:0]  heat;
    logic                         promoted;
    logic                         demoted_valid;
    logic [ttpp_pkg::PAGE_W-1:0]  demoted_page;
    modport source (output valid, output hit_tier, output window_hits, output heat,
                    output promoted, output demoted_valid, output demoted_page,
                    input ready);
    modport sink (input valid, input hit_tier, input window_hits, input heat,
                  input promoted, input demoted_valid, input demoted_page,
                  output ready);
endinterface
`default_nettype wire

### rtl/ttpp_ram.sv
`default_nettype none
module ttpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/ttpp_cell.sv
`default_nettype none
module ttpp_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  ttpp_pkg::t_cell     i_init,
    input  ttpp_pkg::t_cell     i_d,
    output ttpp_pkg::t_cell     o_q
);
    import ttpp_pkg::*;

    t_cell r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= i_init;
        end else if (i_shift) begin
            r_rec <= i_d;
        end
    end

    assign o_q = r_rec;
endmodule
`default_nettype wire

### rtl/three_tier_page_placement.sv
// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   page
// o_res     out  valid/ready   hit_tier, window_hits, heat, promoted, demoted_*
// apb       in   psel/penable  paddr, pwdata (prdata back, pready tied high)
//
// A request first drops from the window the entries that fall out of it, then
// inserts its page and makes two passes round the 128-cell page chain, one for
// ageing and stale counting, one for promotion, coldest search and cooling.
// Synchronous active-low reset restores the reset placement; no clearing pass.
// A finished result waits in the output register; a new beat is taken
// meanwhile and its result is held until the previous one leaves.
`default_nettype none
module three_tier_page_placement (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ttpp_req_if.sink                        i_req,
    ttpp_res_if.source                      o_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ttpp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ttpp_pkg::DATA_W-1:0] pwdata,
    output logic [ttpp_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import ttpp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TRIM_CHK, S_TRIM_RD, S_TRIM_WR, S_INS, S_INS_WR,
        S_PASS_A, S_DECIDE, S_PASS_B, S_FIN
    } t_state;

    // configuration
    logic [CAP_W-1:0]  r_top_cap, r_mid_cap, r_stale_need, r_cool_per;
    logic [AGE_W-1:0]  r_top_lim, r_mid_lim;
    logic [HEAT_W-1:0] r_cool_step;
    logic [CNT_W-1:0]  r_win_len;

    logic       w_cfg_wr;
    logic [2:0] w_reg;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_cap    <= CAP_W'(RESET_TOP);
            r_mid_cap    <= CAP_W'(RESET_MID);
            r_top_lim    <= 10'd60;
            r_mid_lim    <= 10'd120;
            r_stale_need <= 8'd2;
            r_cool_per   <= 8'd20;
            r_cool_step  <= 16'd1638;
            r_win_len    <= 11'd1000;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_TOP_CAP:   r_top_cap    <= pwdata[CAP_W-1:0];
                REG_MID_CAP:   r_mid_cap    <= pwdata[CAP_W-1:0];
                REG_TOP_LIMIT: r_top_lim    <= pwdata[AGE_W-1:0];
                REG_MID_LIMIT: r_mid_lim    <= pwdata[AGE_W-1:0];
                REG_STALE:     r_stale_need <= pwdata[CAP_W-1:0];
                REG_COOL_PER:  r_cool_per   <= pwdata[CAP_W-1:0];
                REG_COOL_STEP: r_cool_step  <= pwdata[HEAT_W-1:0];
                REG_WIN_LEN:   r_win_len    <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_TOP_CAP:   prdata = DATA_W'(r_top_cap);
            REG_MID_CAP:   prdata = DATA_W'(r_mid_cap);
            REG_TOP_LIMIT: prdata = DATA_W'(r_top_lim);
            REG_MID_LIMIT: prdata = DATA_W'(r_mid_lim);
            REG_STALE:     prdata = DATA_W'(r_stale_need);
            REG_COOL_PER:  prdata = DATA_W'(r_cool_per);
            REG_COOL_STEP: prdata = DATA_W'(r_cool_step);
            REG_WIN_LEN:   prdata = DATA_W'(r_win_len);
            default:       prdata = '0;
        endcase
    end

    // control and payload registers
    t_state             r_state;
    logic [PAGE_W-1:0]  r_idx, r_page, r_q, r_best_idx, r_dem_page;
    logic [CNT_W-1:0]   r_wl, r_fill, r_hits;
    logic [RING_AW-1:0] r_ptr;
    logic [TIER_W-1:0]  r_hit, r_dem_tier;
    logic [HEAT_W-1:0]  r_heat;
    logic [CAP_W-1:0]   r_st0, r_st1, r_top_occ, r_mid_occ;
    logic               r_upper, r_prom, r_need_dem, r_dem_pend, r_bad;
    logic [HEAT_W:0]    r_best;
    logic [NUM_PAGES-1:0] r_cnt_vld;
    logic               r_cnt_rvld;

    logic               r_out_valid, r_out_prom, r_out_dval;
    logic [TIER_W-1:0]  r_out_tier;
    logic [CNT_W-1:0]   r_out_hits;
    logic [HEAT_W-1:0]  r_out_heat;
    logic [PAGE_W-1:0]  r_out_dpage;

    // memories
    logic               w_ring_we;
    logic [RING_AW-1:0] w_ring_raddr;
    logic [PAGE_W-1:0]  w_ring_rdata;
    logic               w_cnt_we;
    logic [PAGE_W-1:0]  w_cnt_waddr, w_cnt_raddr;
    logic [CNT_W-1:0]   w_cnt_wdata, w_cnt_rdata, w_cnt_val, w_cnt_inc;

    assign w_ring_we    = (r_state == S_INS);
    assign w_ring_raddr = r_ptr - r_fill[RING_AW-1:0];

    ttpp_ram #(.WIDTH(PAGE_W), .DEPTH(WINDOW_MAX)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (r_ptr),
        .i_wdata (r_page),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_rdata)
    );

    assign w_cnt_val   = r_cnt_rvld ? w_cnt_rdata : '0;
    assign w_cnt_inc   = (w_cnt_val == {CNT_W{1'b1}}) ? w_cnt_val : w_cnt_val + 1'b1;
    assign w_cnt_raddr = (r_state == S_TRIM_RD) ? w_ring_rdata : r_page;
    assign w_cnt_we    = (r_state == S_TRIM_WR) || (r_state == S_INS_WR);
    assign w_cnt_waddr = (r_state == S_TRIM_WR) ? r_q : r_page;
    always_comb begin
        if (r_state == S_TRIM_WR)
            w_cnt_wdata = (w_cnt_val != '0) ? w_cnt_val - 1'b1 : w_cnt_val;
        else
            w_cnt_wdata = w_cnt_inc;
    end

    ttpp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld  <= '0;
            r_cnt_rvld <= 1'b0;
        end else begin
            r_cnt_rvld <= r_cnt_vld[w_cnt_raddr];
            if (w_cnt_we)
                r_cnt_vld[w_cnt_waddr] <= 1'b1;
        end
    end

    // page chain: head reads cell 0 and writes back into the last cell
    t_cell w_q [NUM_PAGES];
    t_cell w_wb, w_head;
    logic  w_shift;

    assign w_shift = (r_state == S_PASS_A) || (r_state == S_PASS_B);
    assign w_head  = w_q[0];

    for (genvar k = 0; k < NUM_PAGES; k++) begin : g_chain
        t_cell w_init;
        t_cell w_d;
        always_comb begin
            w_init.tier = (k < RESET_TOP) ? TIER_TOP :
                          (k < RESET_TOP + RESET_MID) ? TIER_MID : TIER_SLOW;
            w_init.heat = HEAT_RESET;
            w_init.idle = '0;
            w_init.age  = '0;
        end
        if (k == NUM_PAGES - 1) begin : g_last
            assign w_d = w_wb;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        ttpp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_init  (w_init),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    // head processing
    logic              w_is_p, w_stale0, w_stale1, w_colder;
    logic [TIER_W-1:0] w_tier_a, w_tier_b, w_upper_t;
    logic [AGE_W-1:0]  w_age_a;
    logic [HEAT_W-1:0] w_heat_p;

    assign w_is_p    = (r_idx == r_page);
    assign w_upper_t = r_upper ? TIER_MID : TIER_TOP;
    assign w_heat_p  = f_heat(r_hits);
    assign w_tier_a  = (r_dem_pend && r_idx == r_dem_page) ? r_dem_tier : w_head.tier;
    assign w_tier_b  = (r_prom && w_is_p) ? w_upper_t : w_head.tier;
    always_comb begin
        if (w_is_p)
            w_age_a = '0;
        else if (w_head.age == {AGE_W{1'b1}})
            w_age_a = w_head.age;
        else
            w_age_a = w_head.age + 1'b1;
    end
    assign w_stale0 = (w_tier_a == TIER_TOP) && (w_age_a > r_top_lim);
    assign w_stale1 = (w_tier_a == TIER_MID) && (w_age_a > r_mid_lim);
    assign w_colder = r_need_dem && (w_tier_b == w_upper_t) &&
                      ({1'b0, w_head.heat} < r_best);

    always_comb begin
        w_wb = w_head;
        if (r_state == S_PASS_A) begin
            w_wb.tier = w_tier_a;
            w_wb.age  = w_age_a;
            w_wb.idle = w_is_p ? '0 : w_head.idle + 1'b1;
            if (w_is_p)
                w_wb.heat = w_heat_p;
        end else begin
            w_wb.tier = w_tier_b;
            // cool after the coldest compare has seen the old heat
            if (r_cool_per != '0 && w_head.idle == r_cool_per) begin
                w_wb.idle = '0;
                w_wb.heat = (w_head.heat > r_cool_step) ? w_head.heat - r_cool_step : '0;
            end
        end
    end

    // promotion decision
    logic             w_upper, w_prom, w_over;
    logic [CAP_W-1:0] w_stale, w_top1, w_mid1;
    always_comb begin
        w_upper = (r_hit == TIER_SLOW);
        w_stale = w_upper ? r_st1 : r_st0;
        w_prom  = ((r_hit == TIER_MID) || (r_hit == TIER_SLOW)) && (w_stale > r_stale_need);
        w_top1  = r_top_occ;
        w_mid1  = r_mid_occ;
        w_over  = 1'b0;
        if (w_prom) begin
            if (!w_upper) begin
                w_top1 = r_top_occ + 1'b1;
                w_mid1 = (r_mid_occ != '0) ? r_mid_occ - 1'b1 : r_mid_occ;
                w_over = w_top1 > r_top_cap;
                if (w_over) begin
                    w_top1 = w_top1 - 1'b1;
                    w_mid1 = w_mid1 + 1'b1;
                end
            end else begin
                w_mid1 = r_mid_occ + 1'b1;
                w_over = w_mid1 > r_mid_cap;
                if (w_over)
                    w_mid1 = w_mid1 - 1'b1;
            end
        end
    end

    logic w_in_acc, w_out_free;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_page      <= '0;
            r_q         <= '0;
            r_wl        <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_hits      <= '0;
            r_hit       <= '0;
            r_heat      <= '0;
            r_st0       <= '0;
            r_st1       <= '0;
            r_upper     <= 1'b0;
            r_prom      <= 1'b0;
            r_need_dem  <= 1'b0;
            r_best      <= '0;
            r_best_idx  <= '0;
            r_dem_pend  <= 1'b0;
            r_dem_page  <= '0;
            r_dem_tier  <= '0;
            r_bad       <= 1'b0;
            r_top_occ   <= CAP_W'(RESET_TOP);
            r_mid_occ   <= CAP_W'(RESET_MID);
            r_out_valid <= 1'b0;
            r_out_tier  <= '0;
            r_out_hits  <= '0;
            r_out_heat  <= '0;
            r_out_prom  <= 1'b0;
            r_out_dval  <= 1'b0;
            r_out_dpage <= '0;
        end else begin
            // a finishing beat reloads the output register itself
            if (r_out_valid && o_res.ready && r_state != S_FIN)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_page <= i_req.page;
                        if (r_win_len == '0)
                            r_wl <= CNT_W'(1);
                        else if (r_win_len > CNT_W'(WINDOW_MAX))
                            r_wl <= CNT_W'(WINDOW_MAX);
                        else
                            r_wl <= r_win_len;
                        if ({1'b0, i_req.page} >= (PAGE_W+1)'(NUM_PAGES)) begin
                            r_bad   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_bad   <= 1'b0;
                            r_state <= S_TRIM_CHK;
                        end
                    end
                end
                S_TRIM_CHK: begin
                    if (r_fill >= r_wl && r_fill != '0) begin
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_TRIM_RD;
                    end else begin
                        r_state <= S_INS;
                    end
                end
                S_TRIM_RD: begin
                    r_q     <= w_ring_rdata;
                    r_state <= S_TRIM_WR;
                end
                S_TRIM_WR: r_state <= S_TRIM_CHK;
                S_INS: begin
                    r_ptr   <= r_ptr + 1'b1;
                    r_fill  <= r_fill + 1'b1;
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_hits  <= w_cnt_inc;
                    r_idx   <= '0;
                    r_st0   <= '0;
                    r_st1   <= '0;
                    r_prom  <= 1'b0;
                    r_need_dem <= 1'b0;
                    r_state <= S_PASS_A;
                end
                S_PASS_A: begin
                    if (w_stale0)
                        r_st0 <= r_st0 + 1'b1;
                    if (w_stale1)
                        r_st1 <= r_st1 + 1'b1;
                    if (w_is_p) begin
                        r_hit  <= w_tier_a;
                        r_heat <= w_heat_p;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == PAGE_W'(NUM_PAGES - 1)) begin
                        r_dem_pend <= 1'b0;
                        r_state    <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_upper    <= w_upper;
                    r_prom     <= w_prom;
                    r_need_dem <= w_over;
                    r_top_occ  <= w_top1;
                    r_mid_occ  <= w_mid1;
                    r_best     <= {1'b1, {HEAT_W{1'b0}}};
                    r_best_idx <= '0;
                    r_state    <= S_PASS_B;
                end
                S_PASS_B: begin
                    if (w_colder) begin
                        r_best     <= {1'b0, w_head.heat};
                        r_best_idx <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == PAGE_W'(NUM_PAGES - 1))
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        if (!r_bad) begin
                            r_dem_pend <= r_need_dem;
                            r_dem_page <= r_best_idx;
                            r_dem_tier <= w_upper_t + 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_out_tier  <= r_bad ? TIER_NONE : r_hit;
                        r_out_hits  <= r_bad ? '0 : r_hits;
                        r_out_heat  <= r_bad ? '0 : r_heat;
                        r_out_prom  <= !r_bad && r_prom;
                        r_out_dval  <= !r_bad && r_need_dem;
                        r_out_dpage <= (!r_bad && r_need_dem) ? r_best_idx : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.hit_tier      = r_out_tier;
    assign o_res.window_hits   = r_out_hits;
    assign o_res.heat          = r_out_heat;
    assign o_res.promoted      = r_out_prom;
    assign o_res.demoted_valid = r_out_dval;
    assign o_res.demoted_page  = r_out_dpage;
endmodule
`default_nettype wire

### rtl/ttpp_checker.sv
`default_nettype none
module ttpp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_res_valid,
    input wire logic                          i_res_ready,
    input wire logic [ttpp_pkg::TIER_W-1:0]   i_hit_tier,
    input wire logic [ttpp_pkg::HEAT_W-1:0]   i_heat,
    input wire logic                          i_promoted,
    input wire logic                          i_demoted_valid,
    input wire logic [ttpp_pkg::PAGE_W-1:0]   i_demoted_page
);
    import ttpp_pkg::*;

    // hold a waiting beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_hit_tier))
        else $error("result dropped while stalled");

    a_prom_tier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_promoted |-> (i_hit_tier == TIER_MID) || (i_hit_tier == TIER_SLOW))
        else $error("promotion from the fast tier");

    a_dem_prom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_demoted_valid |-> i_promoted)
        else $error("demotion without promotion");

    a_dem_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_demoted_valid |-> i_demoted_page == '0)
        else $error("demoted page set without demotion");

    a_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_heat <= HEAT_ONE)
        else $error("heat above one");
endmodule

bind three_tier_page_placement ttpp_checker u_ttpp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_hit_tier      (o_res.hit_tier),
    .i_heat          (o_res.heat),
    .i_promoted      (o_res.promoted),
    .i_demoted_valid (o_res.demoted_valid),
    .i_demoted_page  (o_res.demoted_page)
);
`default_nettype wire
